/* hw/rtl/hsd_pkg.sv */
// shared constants for the 3d heat stencil engine
// value widths, item function codes, register indexes, divide-by-7 constant
// no dependencies
`default_nettype none
package hsd_pkg;
   localparam int VAL_W  = 26;
   localparam int SUM_W  = 29;
   localparam int STEP_W = 16;

   // floor(n / 7) == (n * DIV7_MAGIC) >> DIV7_SHIFT for n below 2**29
   localparam int DIV7_SHIFT = 32;
   localparam logic [29:0] DIV7_MAGIC = 30'd613566757;

   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_RUN   = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   localparam logic [2:0] CSR_SIZE_X   = 3'd0;
   localparam logic [2:0] CSR_SIZE_Y   = 3'd1;
   localparam logic [2:0] CSR_SIZE_Z   = 3'd2;
   localparam logic [2:0] CSR_SOURCE_X = 3'd3;
   localparam logic [2:0] CSR_SOURCE_Y = 3'd4;
   localparam logic [2:0] CSR_SOURCE_Z = 3'd5;
endpackage
`default_nettype wire

/* hw/rtl/hsd_ram.sv */
// generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none
module hsd_ram #(
   parameter int WIDTH = 26,
   parameter int DEPTH = 65536
) (
   input  wire  logic                     clock,
   input  wire  logic                     wr_en,
   input  wire  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire  logic [WIDTH-1:0]         wr_data,
   input  wire  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic       [WIDTH-1:0]         rd_data_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* hw/rtl/hsd_div7.sv */
// floor divide of a seven-term stencil sum by 7 through a reciprocal multiply
// depends on hsd_pkg
`default_nettype none
module hsd_div7 (
   input  wire  logic [hsd_pkg::SUM_W-1:0] sum,
   output logic       [hsd_pkg::VAL_W-1:0] quot
);
   import hsd_pkg::*;

   logic [SUM_W+30-1:0] prod;

   assign prod = (SUM_W+30)'(sum) * (SUM_W+30)'(DIV7_MAGIC);
   // quotient of a sum below 7 * 2**26 fits in the value width
   assign quot = prod[DIV7_SHIFT +: VAL_W];
endmodule
`default_nettype wire

/* hw/rtl/heat_stencil_3d_engine_core.sv */
// top level of the 3d jacobi heat stencil engine
// depends on hsd_pkg, hsd_ram, hsd_div7
`default_nettype none
// The grid lives in one ram holding two banks of MAX_X*MAX_Y*MAX_Z cells of
// 26-bit unsigned temperature (16 fraction bits). A write item stores a
// cell of the current bank and returns at once; a read item passes through
// the read state for the registered ram read. A run item visits every
// cell of the region in use once per time step with a single ram read
// port: seven reads (center, then the six neighbors) and one write per
// cell. One item is in work at a time; the result register lets a new
// item enter while the previous result is taken. Configuration writes are
// taken at any time (csr_ready is tied high) but are meant only for an
// idle block. No clearing pass runs after reset.
module heat_stencil_3d_engine_core #(
   parameter int MAX_X = 32,
   parameter int MAX_Y = 32,
   parameter int MAX_Z = 32
) (
   input  wire  logic                       clock,
   input  wire  logic                       reset,
   input  wire  logic                       req_valid,
   output logic                             req_stall,
   input  wire  logic [1:0]                 req_func,
   input  wire  logic [4:0]                 req_cell_x,
   input  wire  logic [4:0]                 req_cell_y,
   input  wire  logic [4:0]                 req_cell_z,
   input  wire  logic [hsd_pkg::VAL_W-1:0]  req_cell_value,
   input  wire  logic [hsd_pkg::STEP_W-1:0] req_step_count,
   output logic                             rsp_valid,
   input  wire  logic                       rsp_stall,
   output logic [hsd_pkg::VAL_W-1:0]        rsp_read_value,
   output logic                             rsp_done_res,
   input  wire  logic                       csr_valid,
   output logic                             csr_ready,
   input  wire  logic [2:0]                 csr_index,
   input  wire  logic [5:0]                 csr_data
);
   import hsd_pkg::*;

   localparam int CELLS = MAX_X * MAX_Y * MAX_Z;
   localparam int DEPTH = 2 * CELLS;
   localparam int AW    = $clog2(DEPTH);
   localparam int XW    = (MAX_X > 1) ? $clog2(MAX_X) : 1;
   localparam int YW    = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
   localparam int ZW    = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_RUN  = 2'd2;

   // run phases: 0..6 issue reads, 1..7 gather data, 8 writes the cell
   localparam logic [3:0] PH_WRITE = 4'd8;

   function automatic logic [AW-1:0] cell_addr(input logic b, input int x, input int y,
                                                input int z);
      int a;
      a = (b ? CELLS : 0) + (z * MAX_Y + y) * MAX_X + x;
      return a[AW-1:0];
   endfunction

   function automatic int clamp_size(input logic [5:0] v, input int maxv);
      int r;
      r = int'(v);
      if (r == 0) r = 1;
      if (r > maxv) r = maxv;
      return r;
   endfunction

   // configuration
   logic [5:0] size_x_ff, size_y_ff, size_z_ff;
   logic [4:0] src_x_ff, src_y_ff, src_z_ff;

   // control
   logic [1:0]        state_ff, state_in;
   logic [3:0]        ph_ff, ph_in;
   logic              bank_ff, bank_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [XW-1:0]     x_ff, x_in;
   logic [YW-1:0]     y_ff, y_in;
   logic [ZW-1:0]     z_ff, z_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [VAL_W-1:0]  c_ff, c_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic             rsp_done_ff, rsp_done_in;

   // ram ports
   logic             wr_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [VAL_W-1:0] wr_data, rd_data;
   logic [VAL_W-1:0] quot;

   logic req_take, in_grid, last_cell, is_source;
   int   nx, ny, nz, cx, cy, cz, bx, by, bz;

   hsd_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data_ff(rd_data)
   );

   hsd_div7 u_div7 (
      .sum (sum_ff),
      .quot(quot)
   );

   // an item enters only when idle and the result slot is free or draining
   assign req_stall = !((state_ff == ST_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_done_res   = rsp_done_ff;

   assign in_grid = (int'(req_cell_x) < MAX_X) && (int'(req_cell_y) < MAX_Y) &&
                    (int'(req_cell_z) < MAX_Z);

   always_comb begin
      nx = clamp_size(size_x_ff, MAX_X);
      ny = clamp_size(size_y_ff, MAX_Y);
      nz = clamp_size(size_z_ff, MAX_Z);
      cx = int'(x_ff);
      cy = int'(y_ff);
      cz = int'(z_ff);
      last_cell = (cx == nx - 1) && (cy == ny - 1) && (cz == nz - 1);
      is_source = (cx == int'(src_x_ff)) && (cy == int'(src_y_ff)) &&
                  (cz == int'(src_z_ff));
      // neighbor outside the region reads the center again
      bx = cx;
      by = cy;
      bz = cz;
      case (ph_ff)
         4'd1: if (cx != 0) bx = cx - 1;
         4'd2: if (cx + 1 < nx) bx = cx + 1;
         4'd3: if (cy != 0) by = cy - 1;
         4'd4: if (cy + 1 < ny) by = cy + 1;
         4'd5: if (cz != 0) bz = cz - 1;
         4'd6: if (cz + 1 < nz) bz = cz + 1;
         default: ;
      endcase
   end

   always_comb begin
      if (state_ff == ST_RUN) begin
         rd_addr = cell_addr(bank_ff, bx, by, bz);
      end else begin
         rd_addr = cell_addr(bank_ff, int'(req_cell_x), int'(req_cell_y), int'(req_cell_z));
      end
      if (state_ff == ST_RUN) begin
         wr_en   = (ph_ff == PH_WRITE);
         wr_addr = cell_addr(!bank_ff, cx, cy, cz);
         wr_data = is_source ? c_ff : quot;
      end else begin
         wr_en   = req_take && (req_func == FUNC_WRITE) && in_grid;
         wr_addr = cell_addr(bank_ff, int'(req_cell_x), int'(req_cell_y), int'(req_cell_z));
         wr_data = req_cell_value;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ph_in        = ph_ff;
      bank_in      = bank_ff;
      steps_in     = steps_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      sum_in       = sum_ff;
      c_in         = c_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_done_in  = rsp_done_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_func)
                  FUNC_WRITE: begin
                     rsp_valid_in = 1'b1;
                     rsp_value_in = '0;
                     rsp_done_in  = 1'b1;
                  end
                  FUNC_READ: begin
                     state_in    = ST_READ;
                     rsp_done_in = in_grid;
                  end
                  FUNC_RUN: begin
                     if (req_step_count == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_value_in = '0;
                        rsp_done_in  = 1'b1;
                     end else begin
                        state_in = ST_RUN;
                        steps_in = req_step_count;
                        ph_in    = '0;
                        x_in     = '0;
                        y_in     = '0;
                        z_in     = '0;
                     end
                  end
                  default: begin
                     // unknown function: no effect, not done
                     rsp_valid_in = 1'b1;
                     rsp_value_in = '0;
                     rsp_done_in  = 1'b0;
                  end
               endcase
            end
         end
         ST_READ: begin
            // done flag holds the grid bounds check taken at accept
            rsp_valid_in = 1'b1;
            rsp_value_in = rsp_done_ff ? rd_data : '0;
            rsp_done_in  = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_RUN: begin
            if (ph_ff == 4'd1) begin
               sum_in = SUM_W'(rd_data);
               c_in   = rd_data;
            end else if (ph_ff != 4'd0 && ph_ff != PH_WRITE) begin
               sum_in = sum_ff + SUM_W'(rd_data);
            end
            if (ph_ff == PH_WRITE) begin
               ph_in = '0;
               if (last_cell) begin
                  x_in    = '0;
                  y_in    = '0;
                  z_in    = '0;
                  bank_in = !bank_ff;
                  steps_in = steps_ff - 1'b1;
                  if (steps_ff == STEP_W'(1)) begin
                     state_in     = ST_IDLE;
                     rsp_valid_in = 1'b1;
                     rsp_value_in = '0;
                     rsp_done_in  = 1'b1;
                  end
               end else if (cx + 1 < nx) begin
                  x_in = x_ff + 1'b1;
               end else if (cy + 1 < ny) begin
                  x_in = '0;
                  y_in = y_ff + 1'b1;
               end else begin
                  x_in = '0;
                  y_in = '0;
                  z_in = z_ff + 1'b1;
               end
            end else begin
               ph_in = ph_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ph_ff        <= '0;
         bank_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         size_x_ff    <= 6'd32;
         size_y_ff    <= 6'd32;
         size_z_ff    <= 6'd32;
         src_x_ff     <= 5'd8;
         src_y_ff     <= 5'd8;
         src_z_ff     <= 5'd8;
      end else begin
         state_ff     <= state_in;
         ph_ff        <= ph_in;
         bank_ff      <= bank_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SIZE_X:   size_x_ff <= csr_data;
               CSR_SIZE_Y:   size_y_ff <= csr_data;
               CSR_SIZE_Z:   size_z_ff <= csr_data;
               CSR_SOURCE_X: src_x_ff  <= csr_data[4:0];
               CSR_SOURCE_Y: src_y_ff  <= csr_data[4:0];
               CSR_SOURCE_Z: src_z_ff  <= csr_data[4:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      steps_ff     <= steps_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      z_ff         <= z_in;
      sum_ff       <= sum_in;
      c_ff         <= c_in;
      rsp_value_ff <= rsp_value_in;
      rsp_done_ff  <= rsp_done_in;
   end

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> ph_ff <= PH_WRITE)
      else $error("run phase out of range");

   a_read_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> rsp_valid_ff)
      else $error("read item gave no result");

   a_run_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> !rsp_valid_ff)
      else $error("result pending during a run");

   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && ph_ff == PH_WRITE && last_cell && steps_ff == STEP_W'(1))
      |=> (state_ff == ST_IDLE && rsp_valid_ff && rsp_done_ff))
      else $error("run did not finish cleanly");
endmodule
`default_nettype wire

/* test/heat_stencil_3d_engine_core_checker.sv */
// result checker for the 3d heat stencil engine: watches the item, result and csr channels
// keeps its own grid banks and settings, predicts each result and compares in order
// depends on hsd_pkg
`default_nettype none
module heat_stencil_3d_engine_core_checker (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_stall,
   input  wire logic [1:0]                 req_func,
   input  wire logic [4:0]                 req_cell_x,
   input  wire logic [4:0]                 req_cell_y,
   input  wire logic [4:0]                 req_cell_z,
   input  wire logic [hsd_pkg::VAL_W-1:0]  req_cell_value,
   input  wire logic [hsd_pkg::STEP_W-1:0] req_step_count,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   input  wire logic [hsd_pkg::VAL_W-1:0]  rsp_read_value,
   input  wire logic                       rsp_done_res,
   input  wire logic                       csr_valid,
   input  wire logic                       csr_ready,
   input  wire logic [2:0]                 csr_index,
   input  wire logic [5:0]                 csr_data,
   output int                              fail_count,
   output int                              outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import hsd_pkg::*;

   localparam int GRID_DIM = 32;
   localparam int BANK_CELLS = GRID_DIM * GRID_DIM * GRID_DIM;

   typedef struct packed {
      logic [VAL_W-1:0] read_value;
      logic             done_res;
   } cell_rsp_type;

   logic [VAL_W-1:0] temp_mem [0:2*BANK_CELLS-1];
   logic             live_bank;
   logic [5:0]       dim_cfg [0:2];
   logic [4:0]       src_cfg [0:2];
   cell_rsp_type     cell_rsp_q [$];
   int               errors = 0;

   assign fail_count = errors;
   initial outstanding = 0;

   function automatic int cell_addr(input logic b, input int x, input int y, input int z);
      return int'(b) * BANK_CELLS + (z * GRID_DIM + y) * GRID_DIM + x;
   endfunction

   function automatic int used_dim(input logic [5:0] v);
      if (v == 6'd0) return 1;
      if (int'(v) > GRID_DIM) return GRID_DIM;
      return int'(v);
   endfunction

   // one jacobi step from the live bank into the other, then swap
   function automatic void apply_time_step();
      int nx, ny, nz;
      logic [SUM_W-1:0] acc;
      logic [VAL_W-1:0] c;
      logic nb;
      nx = used_dim(dim_cfg[0]);
      ny = used_dim(dim_cfg[1]);
      nz = used_dim(dim_cfg[2]);
      nb = ~live_bank;
      for (int z = 0; z < nz; z++) begin
         for (int y = 0; y < ny; y++) begin
            for (int x = 0; x < nx; x++) begin
               c = temp_mem[cell_addr(live_bank, x, y, z)];
               if (x == src_cfg[0] && y == src_cfg[1] && z == src_cfg[2]) begin
                  temp_mem[cell_addr(nb, x, y, z)] = c;
               end else begin
                  acc = SUM_W'(c);
                  acc += (x != 0)      ? SUM_W'(temp_mem[cell_addr(live_bank, x-1, y, z)]) : SUM_W'(c);
                  acc += (x + 1 < nx)  ? SUM_W'(temp_mem[cell_addr(live_bank, x+1, y, z)]) : SUM_W'(c);
                  acc += (y != 0)      ? SUM_W'(temp_mem[cell_addr(live_bank, x, y-1, z)]) : SUM_W'(c);
                  acc += (y + 1 < ny)  ? SUM_W'(temp_mem[cell_addr(live_bank, x, y+1, z)]) : SUM_W'(c);
                  acc += (z != 0)      ? SUM_W'(temp_mem[cell_addr(live_bank, x, y, z-1)]) : SUM_W'(c);
                  acc += (z + 1 < nz)  ? SUM_W'(temp_mem[cell_addr(live_bank, x, y, z+1)]) : SUM_W'(c);
                  temp_mem[cell_addr(nb, x, y, z)] = VAL_W'(acc / 7);
               end
            end
         end
      end
      live_bank = nb;
   endfunction

   function automatic cell_rsp_type predict_item();
      cell_rsp_type r;
      r.read_value = '0;
      r.done_res = 1'b1;
      case (req_func)
         FUNC_WRITE: temp_mem[cell_addr(live_bank, req_cell_x, req_cell_y, req_cell_z)] =
                        req_cell_value;
         FUNC_RUN: begin
            for (int t = 0; t < int'(req_step_count); t++) apply_time_step();
         end
         FUNC_READ: r.read_value = temp_mem[cell_addr(live_bank, req_cell_x, req_cell_y,
                                                      req_cell_z)];
         default: r.done_res = 1'b0;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      cell_rsp_type want;
      if (reset) begin
         live_bank = 1'b0;
         for (int i = 0; i < 3; i++) begin
            dim_cfg[i] = 6'd32;
            src_cfg[i] = 5'd8;
         end
         cell_rsp_q.delete();
         outstanding <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (cell_rsp_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result read_value=%h done_res=%b", $time,
                        rsp_read_value, rsp_done_res);
            end else begin
               want = cell_rsp_q.pop_front();
               if (rsp_read_value !== want.read_value) begin
                  errors++;
                  $display("%0t: read_value expected %h actual %h", $time,
                           want.read_value, rsp_read_value);
               end
               if (rsp_done_res !== want.done_res) begin
                  errors++;
                  $display("%0t: done_res expected %b actual %b", $time,
                           want.done_res, rsp_done_res);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SIZE_X:   dim_cfg[0] = csr_data;
               CSR_SIZE_Y:   dim_cfg[1] = csr_data;
               CSR_SIZE_Z:   dim_cfg[2] = csr_data;
               CSR_SOURCE_X: src_cfg[0] = csr_data[4:0];
               CSR_SOURCE_Y: src_cfg[1] = csr_data[4:0];
               CSR_SOURCE_Z: src_cfg[2] = csr_data[4:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) cell_rsp_q.push_back(predict_item());
         outstanding <= cell_rsp_q.size();
      end
   end
endmodule
`default_nettype wire

/* test/heat_stencil_3d_engine_core_test.sv */
// testbench top for heat_stencil_3d_engine_core: clock, reset, stimulus and verdict
// depends on hsd_pkg, the engine rtl and heat_stencil_3d_engine_core_checker
`default_nettype none
module heat_stencil_3d_engine_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import hsd_pkg::*;

   localparam logic [1:0] FUNC_NONE = 2'd3;   // unused function code
   localparam int GRID_DIM = 32;
   localparam int BANK_CELLS = GRID_DIM * GRID_DIM * GRID_DIM;
   localparam int ITEM_GOAL = 1400;
   localparam int STALL_LIMIT = 3000000;       // above the longest run

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_func = FUNC_WRITE;
   logic [4:0]          req_cell_x = '0;
   logic [4:0]          req_cell_y = '0;
   logic [4:0]          req_cell_z = '0;
   logic [VAL_W-1:0]    req_cell_value = '0;
   logic [STEP_W-1:0]   req_step_count = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [VAL_W-1:0]    rsp_read_value;
   logic                rsp_done_res;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [2:0]          csr_index = '0;
   logic [5:0]          csr_data = '0;
   int                  fail_count;
   int                  outstanding;

   // stimulus side bookkeeping: which grid entries hold a value, per bank
   bit                  cell_written [0:2*BANK_CELLS-1];
   bit                  cur_bank = 1'b0;
   logic [5:0]          dim_now [0:2];
   bit                  idle_on = 1'b1;
   int                  items_sent = 0;
   int                  runs_sent = 0;
   int                  reads_sent = 0;
   int                  quiet_cycles = 0;

   heat_stencil_3d_engine_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_cell_x(req_cell_x), .req_cell_y(req_cell_y), .req_cell_z(req_cell_z),
      .req_cell_value(req_cell_value), .req_step_count(req_step_count),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_read_value(rsp_read_value),
      .rsp_done_res(rsp_done_res),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   heat_stencil_3d_engine_core_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_cell_x(req_cell_x), .req_cell_y(req_cell_y), .req_cell_z(req_cell_z),
      .req_cell_value(req_cell_value), .req_step_count(req_step_count),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_read_value(rsp_read_value),
      .rsp_done_res(rsp_done_res),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data),
      .fail_count(fail_count), .outstanding(outstanding)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // result side back-pressure, off during quiet stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= idle_on && ($urandom_range(99) < 12);
      end
   end

   // watchdog: any accepted handshake restarts the count
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)
          || reset) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > STALL_LIMIT) begin
            $display("timeout after %0d cycles with no handshake", quiet_cycles);
            $display("heat_stencil_3d_engine_core regression: fail");
            $finish;
         end
      end
   end

   function automatic int cell_addr(input bit b, input int x, input int y, input int z);
      return int'(b) * BANK_CELLS + (z * GRID_DIM + y) * GRID_DIM + x;
   endfunction

   // size 0 acts as 1, anything past the grid acts as the grid edge
   function automatic int used_dim(input logic [5:0] v);
      if (v == 6'd0) return 1;
      if (int'(v) > GRID_DIM) return GRID_DIM;
      return int'(v);
   endfunction

   function automatic logic [VAL_W-1:0] rand_temp();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return VAL_W'($urandom);
      endcase
   endfunction

   // mark the region as written in the bank a step lands in, track the swaps
   task automatic note_run(input int steps);
      int nx, ny, nz, marks;
      nx = used_dim(dim_now[0]);
      ny = used_dim(dim_now[1]);
      nz = used_dim(dim_now[2]);
      marks = (steps > 2) ? 2 : steps;
      for (int t = 0; t < marks; t++) begin
         for (int z = 0; z < nz; z++)
            for (int y = 0; y < ny; y++)
               for (int x = 0; x < nx; x++) cell_written[cell_addr(~cur_bank, x, y, z)] = 1'b1;
         cur_bank = ~cur_bank;
      end
      if (steps > 2 && ((steps - 2) % 2) == 1) cur_bank = ~cur_bank;
   endtask

   // entered and left at a rising edge; returns once the item is accepted
   task automatic send_item(input logic [1:0] f, input logic [4:0] x, input logic [4:0] y,
                            input logic [4:0] z, input logic [VAL_W-1:0] v,
                            input logic [STEP_W-1:0] steps);
      if (idle_on && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= f;
      req_cell_x     <= x;
      req_cell_y     <= y;
      req_cell_z     <= z;
      req_cell_value <= v;
      req_step_count <= steps;
      do @(posedge clock); while (req_stall);
      items_sent++;
      case (f)
         FUNC_WRITE: cell_written[cell_addr(cur_bank, x, y, z)] = 1'b1;
         FUNC_RUN: begin
            runs_sent++;
            note_run(int'(steps));
         end
         FUNC_READ: reads_sent++;
         default: ;
      endcase
   endtask

   // block until every predicted result is back, then let the pipe drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [5:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_SIZE_X: dim_now[0] = data;
         CSR_SIZE_Y: dim_now[1] = data;
         CSR_SIZE_Z: dim_now[2] = data;
         default: ;
      endcase
   endtask

   task automatic set_grid(input logic [5:0] sx, input logic [5:0] sy, input logic [5:0] sz,
                           input logic [4:0] hx, input logic [4:0] hy, input logic [4:0] hz);
      wait_idle();
      csr_write(CSR_SIZE_X, sx);
      csr_write(CSR_SIZE_Y, sy);
      csr_write(CSR_SIZE_Z, sz);
      csr_write(CSR_SOURCE_X, {1'b0, hx});
      csr_write(CSR_SOURCE_Y, {1'b0, hy});
      csr_write(CSR_SOURCE_Z, {1'b0, hz});
   endtask

   // a run may only read cells that hold a value, so fill the gaps first
   task automatic run_steps(input logic [STEP_W-1:0] steps);
      int nx, ny, nz;
      nx = used_dim(dim_now[0]);
      ny = used_dim(dim_now[1]);
      nz = used_dim(dim_now[2]);
      for (int z = 0; z < nz; z++)
         for (int y = 0; y < ny; y++)
            for (int x = 0; x < nx; x++)
               if (!cell_written[cell_addr(cur_bank, x, y, z)])
                  send_item(FUNC_WRITE, 5'(x), 5'(y), 5'(z), rand_temp(), STEP_W'($urandom));
      send_item(FUNC_RUN, 5'($urandom), 5'($urandom), 5'($urandom), VAL_W'($urandom), steps);
   endtask

   // read a cell if it holds a value, otherwise give it one
   task automatic touch_cell(input bit in_region);
      int x, y, z;
      if (in_region) begin
         x = $urandom_range(used_dim(dim_now[0]) - 1);
         y = $urandom_range(used_dim(dim_now[1]) - 1);
         z = $urandom_range(used_dim(dim_now[2]) - 1);
      end else begin
         x = $urandom_range(31);
         y = $urandom_range(31);
         z = $urandom_range(31);
      end
      if (cell_written[cell_addr(cur_bank, x, y, z)])
         send_item(FUNC_READ, 5'(x), 5'(y), 5'(z), VAL_W'($urandom), STEP_W'($urandom));
      else
         send_item(FUNC_WRITE, 5'(x), 5'(y), 5'(z), rand_temp(), STEP_W'($urandom));
   endtask

   task automatic random_grid();
      logic [5:0] d [0:2];
      logic [4:0] h [0:2];
      int mode;
      mode = $urandom_range(9);
      for (int i = 0; i < 3; i++) d[i] = 6'($urandom_range(4, 1));
      if (mode < 3) begin
         // one long axis, the others degenerate
         for (int i = 0; i < 3; i++) d[i] = ($urandom_range(1) == 0) ? 6'd0 : 6'd1;
         d[mode] = ($urandom_range(1) == 0) ? 6'd32 : 6'd63;
      end else if (mode == 3) begin
         d[2] = 6'd1;
      end
      for (int i = 0; i < 3; i++) begin
         case ($urandom_range(3))
            0: h[i] = 5'd0;
            1: h[i] = 5'd31;
            default: h[i] = 5'($urandom_range(used_dim(d[i]) - 1));
         endcase
      end
      set_grid(d[0], d[1], d[2], h[0], h[1], h[2]);
   endtask

   initial begin
      int phase;
      int pick;
      for (int i = 0; i < 3; i++) dim_now[i] = 6'd32;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: single cell, source outside, field extremes
      set_grid(6'd1, 6'd1, 6'd1, 5'd31, 5'd31, 5'd31);
      send_item(FUNC_WRITE, 5'd0, 5'd0, 5'd0, '1, '0);
      send_item(FUNC_READ, 5'd0, 5'd0, 5'd0, '0, '1);
      send_item(FUNC_RUN, 5'd31, 5'd31, 5'd31, '1, '0);            // zero step count
      send_item(FUNC_READ, 5'd0, 5'd0, 5'd0, '0, '0);
      send_item(FUNC_WRITE, 5'd31, 5'd31, 5'd31, '0, '1);         // outside the region in use
      send_item(FUNC_READ, 5'd31, 5'd31, 5'd31, '1, '1);
      send_item(FUNC_NONE, 5'd31, 5'd31, 5'd31, '1, '1);          // unknown function
      send_item(FUNC_NONE, 5'd0, 5'd0, 5'd0, '0, '0);
      run_steps('1);                                               // longest step count
      send_item(FUNC_READ, 5'd0, 5'd0, 5'd0, '0, '0);
      // source pinned inside, long x axis via oversize value, sizes 0 act as 1
      set_grid(6'd63, 6'd0, 6'd0, 5'd0, 5'd0, 5'd0);
      run_steps(16'd1);
      send_item(FUNC_READ, 5'd0, 5'd0, 5'd0, '0, '0);
      send_item(FUNC_READ, 5'd31, 5'd0, 5'd0, '0, '0);
      set_grid(6'd2, 6'd2, 6'd2, 5'd1, 5'd0, 5'd1);
      run_steps(16'd3);
      send_item(FUNC_READ, 5'd1, 5'd0, 5'd1, '0, '0);
      send_item(FUNC_READ, 5'd0, 5'd1, 5'd0, '0, '0);

      // random phases of mostly well-formed traffic in small regions
      phase = 0;
      while (items_sent < ITEM_GOAL) begin
         idle_on = !(phase >= 4 && phase <= 6);
         random_grid();
         for (int n = 0; n < 40; n++) begin
            pick = $urandom_range(99);
            if (pick < 35) touch_cell(1'b0);
            else if (pick < 75) touch_cell(1'b1);
            else if (pick < 92) run_steps(STEP_W'($urandom_range(3, 1)));
            else if (pick < 95) run_steps('0);
            else send_item(FUNC_NONE, 5'($urandom), 5'($urandom), 5'($urandom),
                           VAL_W'($urandom), STEP_W'($urandom));
            if (n == 20 && phase % 5 == 2) wait_idle();    // sender holds until drained
         end
         phase++;
      end

      idle_on = 1'b1;
      wait_idle();
      repeat (20) @(posedge clock);
      $display("covered %0d items (%0d runs, %0d reads) over %0d random grid settings",
               items_sent, runs_sent, reads_sent, phase);
      $display("settings included single-cell and 32-long grids, sources in and out of region");
      if (fail_count == 0) begin
         $display("heat_stencil_3d_engine_core regression: pass");
      end else begin
         $display("heat_stencil_3d_engine_core regression: fail");
      end
      $finish;
   end
endmodule
`default_nettype wire

/* heat_stencil_3d_engine_core.f */
hw/rtl/hsd_pkg.sv
hw/rtl/hsd_ram.sv
hw/rtl/hsd_div7.sv
hw/rtl/heat_stencil_3d_engine_core.sv
test/heat_stencil_3d_engine_core_checker.sv
test/heat_stencil_3d_engine_core_test.sv
